>>> sv/qmcm_pkg.sv
// ----------------------------------------------------------------------------
// qmcm_pkg
// Shared types, constants and the quarter-wave sine table of the QAM mapper
// and carrier mixer.
// ----------------------------------------------------------------------------
package qmcm_pkg;

    localparam int MAX_SAMPLES     = 64;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int PHASE_BITS      = 32;

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SPS_W     = 7;
    localparam int STEP_W    = 32;
    localparam int BITS_W    = 6;
    localparam int LVL_W     = 4;
    localparam int SIN_W     = 16;
    localparam int MAG_W     = 15;
    localparam int PROD_W    = LVL_W + SIN_W;
    localparam int SAMPLE_W  = 19;
    localparam int QUARTER   = 1 << (TABLE_ADDR_BITS - 2);
    localparam int QIDX_W    = TABLE_ADDR_BITS - 2;

    // apb register map
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam logic [1:0] REG_MOD_MODE = 2'd0;
    localparam logic [1:0] REG_SPS      = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;

    localparam logic [1:0]       MOD_MODE_RST = 2'd0;
    localparam logic [SPS_W-1:0] SPS_RST      = SPS_W'(10);
    localparam logic [STEP_W-1:0] STEP_RST    = 32'd429496730;

    // constellation codes
    localparam logic [1:0] MODE_QPSK  = 2'd0;
    localparam logic [1:0] MODE_QAM16 = 2'd1;
    localparam logic [1:0] MODE_QAM64 = 2'd2;

    localparam logic signed [LVL_W-1:0] LV16 [4] = '{-4'sd3, -4'sd1, 4'sd1, 4'sd3};
    localparam logic signed [LVL_W-1:0] LV64 [8] =
        '{-4'sd7, -4'sd5, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd5, 4'sd7};

    typedef struct packed {
        logic [1:0]        mod_mode;
        logic [SPS_W-1:0]  samples_per_symbol;
        logic [STEP_W-1:0] phase_step;
    } cfg_t;

    // one symbol handed from the front to the sample generator
    typedef struct packed {
        logic signed [LVL_W-1:0] lvl_i;
        logic signed [LVL_W-1:0] lvl_q;
        logic [CNT_W-1:0]        count;
        logic                    restart;
    } sym_entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // odd polynomial coefficients in q30
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;

    // sine magnitude of quarter-wave index u, evaluated at elaboration only
    function automatic logic [MAG_W-1:0] qsin_calc(input int unsigned u);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        z  = 64'(u) << (32 - TABLE_ADDR_BITS);
        z2 = (z * z) >> 30;
        t  = C5 - ((z2 * C7) >> 30);
        t  = C3 - ((z2 * t) >> 30);
        t  = C1 - ((z2 * t) >> 30);
        s  = (z * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[MAG_W-1:0];
    endfunction

    typedef logic [MAG_W-1:0] qsin_rom_t [QUARTER];

    function automatic qsin_rom_t qsin_build();
        qsin_rom_t r;
        for (int j = 0; j < QUARTER; j++) begin
            r[j] = qsin_calc(j);
        end
        return r;
    endfunction

    localparam qsin_rom_t        QSIN_ROM  = qsin_build();
    localparam logic [MAG_W-1:0] QSIN_PEAK = qsin_calc(QUARTER);

    // signed q1.15 sine at table address k, folded over the four quadrants
    function automatic logic signed [SIN_W-1:0] table_sin(
        input logic [TABLE_ADDR_BITS-1:0] k
    );
        logic [1:0]              quad;
        logic [QIDX_W-1:0]       u;
        logic [QIDX_W-1:0]       idx;
        logic [MAG_W-1:0]        mag;
        logic signed [SIN_W-1:0] smag;
        quad = k[TABLE_ADDR_BITS-1 -: 2];
        u    = k[QIDX_W-1:0];
        idx  = quad[0] ? (~u + 1'b1) : u;
        // falling quadrant at offset zero lands on the crest
        mag  = (quad[0] && (u == '0)) ? QSIN_PEAK : QSIN_ROM[idx];
        smag = $signed({1'b0, mag});
        return quad[1] ? -smag : smag;
    endfunction

endpackage

>>> sv/qam_mapper_carrier_mixer.sv
// ----------------------------------------------------------------------------
// qam_mapper_carrier_mixer
// QAM symbol mapper with carrier upconversion: maps each symbol to I/Q levels
// and emits a burst of I*cos / Q*sin samples from a phase accumulator.
// ----------------------------------------------------------------------------
// Each accepted symbol produces samples_per_symbol (clamped to 64, 10 at reset)
// output beats, one per cycle while m_ready is high, and consecutive symbols
// follow each other with no gap; a symbol in the unused mode or with a zero
// count emits nothing: it is dropped at the input unless it carries a restart,
// in which case it still passes through the generator to clear the phase. A
// four-entry queue sits between the input and the generator, so symbols are
// taken while samples are still being sent, and the first sample of a symbol
// passes through the address, lookup and output registers after the generator
// picks it up. Configuration goes through the APB port at byte addresses 0
// (mod_mode), 4 (samples_per_symbol) and 8 (phase_step).
module qam_mapper_carrier_mixer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // symbol input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [qmcm_pkg::BITS_W-1:0]          s_symbol_bits,
    input  logic                                 s_restart,
    // sample output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qmcm_pkg::SAMPLE_W-1:0] m_i_sample,
    output logic signed [qmcm_pkg::SAMPLE_W-1:0] m_q_sample,
    output logic                                 m_last_of_symbol,
    // apb
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qmcm_pkg::ADDR_W-1:0]          paddr,
    input  logic [qmcm_pkg::DATA_W-1:0]          pwdata,
    output logic [qmcm_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import qmcm_pkg::*;

    logic [1:0]        mod_mode_reg, mod_mode_next;
    logic [SPS_W-1:0]  sps_reg, sps_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              wr_en;
    logic [1:0]        reg_idx;
    cfg_t              cfg;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    sym_entry_t push_entry;
    sym_entry_t head_entry;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        mod_mode_next = mod_mode_reg;
        sps_next      = sps_reg;
        step_next     = step_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_MOD_MODE: mod_mode_next = pwdata[1:0];
                REG_SPS:      sps_next      = pwdata[SPS_W-1:0];
                REG_STEP:     step_next     = pwdata[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_mode_reg <= MOD_MODE_RST;
            sps_reg      <= SPS_RST;
            step_reg     <= STEP_RST;
        end else begin
            mod_mode_reg <= mod_mode_next;
            sps_reg      <= sps_next;
            step_reg     <= step_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MOD_MODE: prdata = DATA_W'(mod_mode_reg);
            REG_SPS:      prdata = DATA_W'(sps_reg);
            REG_STEP:     prdata = DATA_W'(step_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.mod_mode           = mod_mode_reg;
    assign cfg.samples_per_symbol = sps_reg;
    assign cfg.phase_step         = step_reg;

    qmcm_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol_bits (s_symbol_bits),
        .s_restart     (s_restart),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    qmcm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    qmcm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .phase_step       (cfg.phase_step),
        .q_valid          (q_valid),
        .q_entry          (head_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_i_sample       (m_i_sample),
        .m_q_sample       (m_q_sample),
        .m_last_of_symbol (m_last_of_symbol)
    );

endmodule

>>> sv/qmcm_front.sv
// ----------------------------------------------------------------------------
// qmcm_front
// Accepts symbols, maps the bit group to I/Q levels by constellation and
// queues the symbol with its sample count for the generator.
// ----------------------------------------------------------------------------
module qmcm_front (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [qmcm_pkg::BITS_W-1:0]      s_symbol_bits,
    input  logic                             s_restart,
    input  qmcm_pkg::cfg_t                   cfg,
    input  logic                             q_full,
    output logic                             q_push,
    output qmcm_pkg::sym_entry_t             q_entry
);
    import qmcm_pkg::*;

    logic                    mode_ok;
    logic signed [LVL_W-1:0] lvl_i;
    logic signed [LVL_W-1:0] lvl_q;
    logic [CNT_W-1:0]        count;
    logic                    keep;

    always_comb begin
        mode_ok = 1'b1;
        lvl_i   = '0;
        lvl_q   = '0;
        unique case (cfg.mod_mode)
            MODE_QPSK: begin
                lvl_i = s_symbol_bits[1] ? 4'sd1 : -4'sd1;
                lvl_q = s_symbol_bits[0] ? 4'sd1 : -4'sd1;
            end
            MODE_QAM16: begin
                lvl_i = LV16[s_symbol_bits[3:2]];
                lvl_q = LV16[s_symbol_bits[1:0]];
            end
            MODE_QAM64: begin
                lvl_i = LV64[s_symbol_bits[5:3]];
                lvl_q = LV64[s_symbol_bits[2:0]];
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
    end

    // clamp the count; an unused mode emits nothing
    assign count = !mode_ok ? '0
                 : (32'(cfg.samples_per_symbol) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES)
                 : CNT_W'(cfg.samples_per_symbol);

    assign q_entry.lvl_i   = lvl_i;
    assign q_entry.lvl_q   = lvl_q;
    assign q_entry.count   = count;
    assign q_entry.restart = s_restart;

    // symbols with no samples only matter when they reset the phase
    assign keep    = (count != '0) || s_restart;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

>>> sv/qmcm_queue.sv
// ----------------------------------------------------------------------------
// qmcm_queue
// Small register fifo of mapped symbols between the front and the generator.
// ----------------------------------------------------------------------------
module qmcm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  qmcm_pkg::sym_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output qmcm_pkg::sym_entry_t head_entry
);
    import qmcm_pkg::*;

    sym_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/qmcm_back.sv
// ----------------------------------------------------------------------------
// qmcm_back
// Sample generator: runs the carrier phase accumulator, looks up sine and
// cosine and scales them by the symbol levels, one sample per cycle unless m_ready stalls it.
// ----------------------------------------------------------------------------
module qmcm_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [qmcm_pkg::STEP_W-1:0]         phase_step,
    input  logic                                q_valid,
    input  qmcm_pkg::sym_entry_t                q_entry,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qmcm_pkg::SAMPLE_W-1:0] m_i_sample,
    output logic signed [qmcm_pkg::SAMPLE_W-1:0] m_q_sample,
    output logic                                m_last_of_symbol
);
    import qmcm_pkg::*;

    // generator
    logic                    active_reg, active_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [LVL_W-1:0] lvl_i_reg, lvl_i_next;
    logic signed [LVL_W-1:0] lvl_q_reg, lvl_q_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;

    // address stage
    logic                       a_valid_reg;
    logic [TABLE_ADDR_BITS-1:0] a_k_reg;
    logic signed [LVL_W-1:0]    a_lvl_i_reg, a_lvl_q_reg;
    logic                       a_last_reg;

    // lookup stage
    logic                    b_valid_reg;
    logic signed [SIN_W-1:0] b_sin_reg, b_cos_reg;
    logic signed [LVL_W-1:0] b_lvl_i_reg, b_lvl_q_reg;
    logic                    b_last_reg;

    // output stage
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_i_reg, m_q_reg;
    logic                       m_last_reg;

    logic                       adv;
    logic                       emit;
    logic                       gen_last;
    logic                       load;
    logic [TABLE_ADDR_BITS-1:0] k_cos;
    logic signed [PROD_W-1:0]   prod_i, prod_q;

    function automatic logic [TABLE_ADDR_BITS-1:0] b_k_cos(
        input logic [TABLE_ADDR_BITS-1:0] k
    );
        return k + TABLE_ADDR_BITS'(QUARTER);
    endfunction

    assign adv      = !m_valid_reg || m_ready;
    assign emit     = adv && active_reg;
    assign gen_last = (cnt_reg == CNT_W'(1));
    assign load     = q_valid && (!active_reg || (emit && gen_last));
    assign q_pop    = load;

    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        lvl_i_next  = lvl_i_reg;
        lvl_q_next  = lvl_q_reg;
        phase_next  = phase_reg;
        if (emit) begin
            cnt_next   = cnt_reg - 1'b1;
            phase_next = phase_reg + phase_step[PHASE_BITS-1:0];
            if (gen_last) begin
                active_next = 1'b0;
            end
        end
        if (load) begin
            active_next = (q_entry.count != '0);
            cnt_next    = q_entry.count;
            lvl_i_next  = q_entry.lvl_i;
            lvl_q_next  = q_entry.lvl_q;
            // restart takes effect after the previous symbol's last sample
            if (q_entry.restart) begin
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            phase_reg  <= '0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_i_reg <= lvl_i_next;
        lvl_q_reg <= lvl_q_next;
    end

    assign k_cos  = b_k_cos(a_k_reg);
    assign prod_i = PROD_W'(b_lvl_i_reg) * PROD_W'(b_cos_reg);
    assign prod_q = PROD_W'(b_lvl_q_reg) * PROD_W'(b_sin_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= emit;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_k_reg     <= phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            a_lvl_i_reg <= lvl_i_reg;
            a_lvl_q_reg <= lvl_q_reg;
            a_last_reg  <= gen_last;

            b_sin_reg   <= table_sin(a_k_reg);
            b_cos_reg   <= table_sin(k_cos);
            b_lvl_i_reg <= a_lvl_i_reg;
            b_lvl_q_reg <= a_lvl_q_reg;
            b_last_reg  <= a_last_reg;

            m_i_reg    <= prod_i[SAMPLE_W-1:0];
            m_q_reg    <= prod_q[SAMPLE_W-1:0];
            m_last_reg <= b_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_i_sample       = m_i_reg;
    assign m_q_sample       = m_q_reg;
    assign m_last_of_symbol = m_last_reg;

endmodule

>>> tb/qmcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmcm_sample_checker
// Watches the configuration port and both streams of the QAM mapper and
// carrier mixer, predicts every sample and compares it with what comes out.
// ----------------------------------------------------------------------------
module qmcm_sample_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [qmcm_pkg::BITS_W-1:0]          s_symbol_bits,
    input  logic                                 s_restart,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [qmcm_pkg::SAMPLE_W-1:0] m_i_sample,
    input  logic signed [qmcm_pkg::SAMPLE_W-1:0] m_q_sample,
    input  logic                                 m_last_of_symbol,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [qmcm_pkg::ADDR_W-1:0]          paddr,
    input  logic [qmcm_pkg::DATA_W-1:0]          pwdata,
    output int                                   fail_count,
    output int                                   pending
);
    import qmcm_pkg::*;

    localparam int MAX_REPORTS = 10;

    // sine polynomial coefficients, q30
    localparam logic [63:0] SIN_K1 = 64'd1686629713;
    localparam logic [63:0] SIN_K3 = 64'd693598668;
    localparam logic [63:0] SIN_K5 = 64'd85569306;
    localparam logic [63:0] SIN_K7 = 64'd5026995;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic                       last;
    } carrier_sample_t;

    carrier_sample_t         expected_samples [$];
    logic [1:0]              cfg_mode;
    logic [SPS_W-1:0]        cfg_sps;
    logic [STEP_W-1:0]       cfg_step;
    logic [PHASE_BITS-1:0]   carrier_phase;

    function automatic int quarter_mag(input int unsigned u);
        logic [63:0] z;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] prod;
        z    = 64'(u) << (32 - TABLE_ADDR_BITS);
        sq   = (z * z) >> 30;
        acc  = SIN_K5 - ((sq * SIN_K7) >> 30);
        acc  = SIN_K3 - ((sq * acc) >> 30);
        acc  = SIN_K1 - ((sq * acc) >> 30);
        prod = (z * acc) >> 30;
        prod = (prod + 64'd16384) >> 15;
        return (prod > 64'd32767) ? 32767 : int'(prod);
    endfunction

    function automatic int carrier_sin(input logic [TABLE_ADDR_BITS-1:0] addr);
        logic [1:0]  quad;
        int unsigned u;
        int          m;
        quad = addr[TABLE_ADDR_BITS-1 -: 2];
        u    = 32'(addr[TABLE_ADDR_BITS-3:0]);
        // falling quadrants read the table mirrored, offset zero is the crest
        if (quad[0]) begin
            u = QUARTER - u;
        end
        m = quarter_mag(u);
        return quad[1] ? -m : m;
    endfunction

    // natural binary index to odd level: 0 -> -(2^n - 1) ... top -> 2^n - 1
    function automatic int axis_level(input int idx, input int nbits);
        return 2 * idx - ((1 << nbits) - 1);
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic predict_symbol(input logic [BITS_W-1:0] bits, input logic restart);
        int                          nbits;
        int                          mask;
        int                          lvl_i;
        int                          lvl_q;
        int                          n;
        int                          sin_v;
        int                          cos_v;
        logic [TABLE_ADDR_BITS-1:0]  addr;
        carrier_sample_t             smp;
        if (restart) begin
            carrier_phase = '0;
        end
        case (cfg_mode)
            MODE_QPSK:  nbits = 1;
            MODE_QAM16: nbits = 2;
            MODE_QAM64: nbits = 3;
            default:    nbits = 0;
        endcase
        if (nbits == 0) begin
            return;
        end
        mask  = (1 << nbits) - 1;
        lvl_i = axis_level((int'(bits) >> nbits) & mask, nbits);
        lvl_q = axis_level(int'(bits) & mask, nbits);
        n     = (cfg_sps > MAX_SAMPLES) ? MAX_SAMPLES : int'(cfg_sps);
        for (int j = 0; j < n; j++) begin
            addr           = carrier_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            sin_v          = carrier_sin(addr);
            cos_v          = carrier_sin(TABLE_ADDR_BITS'(addr + QUARTER));
            smp.i_sample   = SAMPLE_W'(lvl_i * cos_v);
            smp.q_sample   = SAMPLE_W'(lvl_q * sin_v);
            smp.last       = (j + 1 == n);
            expected_samples.insert(expected_samples.size(), smp);
            carrier_phase  = carrier_phase + cfg_step;
        end
    endtask

    task automatic check_sample();
        carrier_sample_t want;
        if (expected_samples.size() == 0) begin
            note_mismatch($sformatf("unexpected sample beat i=%0d q=%0d last=%0b",
                                    m_i_sample, m_q_sample, m_last_of_symbol));
            return;
        end
        want = expected_samples.pop_front();
        if (m_i_sample !== want.i_sample || m_q_sample !== want.q_sample ||
            m_last_of_symbol !== want.last) begin
            note_mismatch($sformatf(
                "sample mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                $signed(want.i_sample), $signed(want.q_sample), want.last,
                m_i_sample, m_q_sample, m_last_of_symbol));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode      = MOD_MODE_RST;
            cfg_sps       = SPS_RST;
            cfg_step      = STEP_RST;
            carrier_phase = '0;
            fail_count    = 0;
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_MOD_MODE: cfg_mode = pwdata[1:0];
                    REG_SPS:      cfg_sps  = pwdata[SPS_W-1:0];
                    REG_STEP:     cfg_step = pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_symbol(s_symbol_bits, s_restart);
            end
            if (m_valid && m_ready) begin
                check_sample();
            end
        end
        pending = expected_samples.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives symbols and register writes into the QAM mapper and carrier mixer
// under several idling patterns and settings; the checker beside the block
// predicts and compares every sample beat.
// ----------------------------------------------------------------------------
module tb_top;
    import qmcm_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         SETTLE_CYCLES    = 32;
    localparam int         ITEMS_PER_REGIME = 64;
    localparam int         SEGMENT_ITEMS    = 16;
    localparam int         SILENT_ITEMS     = 4;
    localparam logic [1:0] MODE_SPARE       = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [BITS_W-1:0]          s_symbol_bits;
    logic                       s_restart;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_i_sample;
    logic signed [SAMPLE_W-1:0] m_q_sample;
    logic                       m_last_of_symbol;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    int fail_count;
    int pending;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    qam_mapper_carrier_mixer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_symbol_bits    (s_symbol_bits),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_i_sample       (m_i_sample),
        .m_q_sample       (m_q_sample),
        .m_last_of_symbol (m_last_of_symbol),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    qmcm_sample_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_symbol_bits    (s_symbol_bits),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_i_sample       (m_i_sample),
        .m_q_sample       (m_q_sample),
        .m_last_of_symbol (m_last_of_symbol),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // sample sink: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_served + 1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL qam_mapper_carrier_mixer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_symbol(input logic [BITS_W-1:0] bits, input logic restart);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_symbol_bits <= bits;
        s_restart     <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // symbols with no samples may still sit in the queue after the last beat
    task automatic load_setup(input logic [1:0] mode, input logic [SPS_W-1:0] sps,
                              input logic [STEP_W-1:0] step);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        reg_write(REG_MOD_MODE, DATA_W'(mode));
        reg_write(REG_SPS, DATA_W'(sps));
        reg_write(REG_STEP, DATA_W'(step));
    endtask

    task automatic run_regime(input int tx_pct, input int rx_pct,
                              input bit with_hold, input bit with_pause);
        int                useful;
        int                n_items;
        int                r;
        bit                first;
        bit                productive;
        logic [1:0]        mode;
        logic [SPS_W-1:0]  sps;
        logic [STEP_W-1:0] step;
        useful = 0;
        first  = 1'b1;
        wait_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (useful < ITEMS_PER_REGIME) begin
            r    = $urandom_range(15);
            mode = (r == 0 && !first) ? MODE_SPARE : 2'(r % 3);
            r    = $urandom_range(19);
            case (r)
                0:       sps = first ? SPS_W'(1) : '0;
                1:       sps = SPS_W'(MAX_SAMPLES);
                2:       sps = SPS_W'($urandom_range(127, MAX_SAMPLES + 1));
                3:       sps = SPS_W'($urandom_range(MAX_SAMPLES - 1, 13));
                default: sps = SPS_W'($urandom_range(12, 1));
            endcase
            step = ($urandom_range(3) == 0) ? STEP_W'($urandom_range(1 << 24)) : $urandom;
            load_setup(mode, sps, step);
            productive = (mode != MODE_SPARE) && (sps != '0);
            n_items    = productive ? SEGMENT_ITEMS : SILENT_ITEMS;
            // sink stops long enough for the block to fill and stall the input
            if (first && with_hold) begin
                hold_requests = hold_requests + 1;
            end
            for (int j = 0; j < n_items; j++) begin
                if (with_pause && j == SEGMENT_ITEMS / 2) begin
                    wait_drained();
                end
                send_symbol(BITS_W'($urandom_range(63)), ($urandom_range(7) == 0));
            end
            if (productive) begin
                useful = useful + n_items;
            end
            first = 1'b0;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_symbol_bits = '0;
        s_restart     = 1'b0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // settings out of reset
        send_symbol(6'd0, 1'b1);
        send_symbol(6'd3, 1'b0);

        // qpsk, one sample per symbol, phase going backwards; high bits ignored
        load_setup(MODE_QPSK, SPS_W'(1), 32'hFFFF_FFFF);
        send_symbol(6'd0, 1'b1);
        send_symbol(6'd1, 1'b0);
        send_symbol(6'd2, 1'b0);
        send_symbol(6'd3, 1'b0);
        send_symbol(6'h3C, 1'b0);

        // qam16, full burst at a quarter turn per sample
        load_setup(MODE_QAM16, SPS_W'(MAX_SAMPLES), 32'h4000_0000);
        send_symbol(6'd0, 1'b0);
        send_symbol(6'd15, 1'b1);
        send_symbol(6'h30, 1'b0);

        // qam64, count above the maximum is clamped
        load_setup(MODE_QAM64, SPS_W'(127), 32'h0040_0000);
        send_symbol(6'd0, 1'b0);
        send_symbol(6'd63, 1'b0);
        send_symbol(6'h2A, 1'b0);
        send_symbol(6'h15, 1'b1);

        // unused mode emits nothing but its restart still clears the phase
        load_setup(MODE_SPARE, SPS_W'(5), 32'h1234_5678);
        send_symbol(6'd7, 1'b1);
        load_setup(MODE_QAM64, SPS_W'(3), '0);
        send_symbol(6'd9, 1'b0);

        // zero count emits nothing and keeps the phase unless it carries a restart
        load_setup(MODE_QAM16, '0, 32'h2000_0000);
        send_symbol(6'd5, 1'b0);
        send_symbol(6'd6, 1'b1);
        load_setup(MODE_QAM16, SPS_W'(2), 32'h2000_0000);
        send_symbol(6'd10, 1'b0);

        run_regime(21, 67, 1'b1, 1'b0);
        run_regime(67, 21, 1'b0, 1'b1);
        run_regime(0, 0, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS qam_mapper_carrier_mixer");
        end else begin
            $display("FAIL qam_mapper_carrier_mixer");
        end
        $finish;
    end

endmodule
